>>> hw/rtl/exponential_backoff_jitter_defines.svh
// ----------------------------------------------------------------------------
// Exponential backoff assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH
`define EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBJ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EBJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ebj_pkg.sv
// ----------------------------------------------------------------------------
// ebj_pkg
// Constants and types shared by the backoff block and its serial units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ebj_pkg;

  // Exponent cap on the doubling of the initial delay.
  localparam int unsigned EXP_CAP = 16;
  localparam int unsigned EXP_W   = $clog2(EXP_CAP + 1);

  // Splitmix64 finalizer constants and channel seed constants.
  localparam logic [63:0] SEED_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SEED_MUL_B   = 64'h94d049bb133111eb;
  localparam logic [63:0] CHAN_MARKET  = 64'h00004d41524b4554;
  localparam logic [63:0] CHAN_ACCOUNT = 64'h004143434f554e54;
  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  // Serial units work one bit of a 64-bit operand per cycle.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned STEPS  = WORD_W;
  localparam int unsigned STEP_W = $clog2(STEPS);

  // Divisor is 5 or 2*span+1, with span below 2^30.
  localparam int unsigned DSR_W  = 33;
  localparam int unsigned SPAN_W = 30;
  localparam logic [DSR_W-1:0] SPAN_DIVISOR = DSR_W'(5);

  // Operation codes carried with each input transaction.
  localparam logic OP_NEXT  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_INITIAL = 2'd0;
  localparam logic [1:0] REG_MAXIMUM = 2'd1;
  localparam logic [1:0] REG_STABLE  = 2'd2;
  localparam logic [1:0] REG_CHANNEL = 2'd3;

  // Status of a serial unit as seen by its controller.
  typedef struct packed {
    logic busy;
    logic done;
  } serial_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ebj_serial_mul.sv
// ----------------------------------------------------------------------------
// ebj_serial_mul
// Bit-serial shift-and-add multiplier keeping the low 64 product bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebj_serial_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ebj_pkg::WORD_W-1:0]    a_in,
  input  wire logic [ebj_pkg::WORD_W-1:0]    b_in,
  output logic      [ebj_pkg::WORD_W-1:0]    product,
  output ebj_pkg::serial_stat_t              stat
);

  logic [ebj_pkg::WORD_W-1:0] a_r, a_nxt;
  logic [ebj_pkg::WORD_W-1:0] b_r, b_nxt;
  logic [ebj_pkg::WORD_W-1:0] acc_r, acc_nxt;
  logic [ebj_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // One multiplier bit per cycle: add the shifted multiplicand when set.
      acc_nxt  = acc_r + (b_r[0] ? a_r : '0);
      a_nxt    = {a_r[ebj_pkg::WORD_W-2:0], 1'b0};
      b_nxt    = {1'b0, b_r[ebj_pkg::WORD_W-1:1]};
      step_nxt = step_r + 1'b1;
      if (step_r == ebj_pkg::STEP_W'(ebj_pkg::STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/ebj_serial_div.sv
// ----------------------------------------------------------------------------
// ebj_serial_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ebj_serial_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ebj_pkg::WORD_W-1:0]    dividend,
  input  wire logic [ebj_pkg::DSR_W-1:0]     divisor,
  output logic      [ebj_pkg::WORD_W-1:0]    quotient,
  output logic      [ebj_pkg::DSR_W-1:0]     remainder,
  output ebj_pkg::serial_stat_t              stat
);

  // The dividend shifts out at the top while quotient bits shift in below.
  logic [ebj_pkg::WORD_W-1:0] dvd_r, dvd_nxt;
  logic [ebj_pkg::DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [ebj_pkg::DSR_W-1:0]  rem_r, rem_nxt;
  logic [ebj_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [ebj_pkg::DSR_W:0]    rem_sh;
  logic [ebj_pkg::DSR_W+1:0]  diff;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[ebj_pkg::WORD_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[ebj_pkg::DSR_W+1]) begin
        rem_nxt = rem_sh[ebj_pkg::DSR_W-1:0];
        dvd_nxt = {dvd_r[ebj_pkg::WORD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[ebj_pkg::DSR_W-1:0];
        dvd_nxt = {dvd_r[ebj_pkg::WORD_W-2:0], 1'b1};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == ebj_pkg::STEP_W'(ebj_pkg::STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = dvd_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/exponential_backoff_jitter.sv
// Flow: a retry request passes through the base step, two bit-serial
//   multiplies (with base / 5 alongside the first) and a bit-serial modulo;
//   the modulo pass is skipped when the jitter span is zero. A new request
//   is taken only once the previous delay has gone to the output register.
// A clear command zeroes the failure counter and gives no result. Synchronous
//   active-low reset clears the failure counter, the registers, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// exponential_backoff_jitter
// Reconnect backoff with a failure counter and splitmix64-derived jitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "exponential_backoff_jitter_defines.svh"

module exponential_backoff_jitter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata: [0] reached_ready, [32:1] lifetime_ms, [39:33] zero.
  input  wire logic [39:0] in_tdata,
  // in_tuser: [0] op (0 request next delay, 1 clear failure counter).
  input  wire logic        in_tuser,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: [31:0] delay_ms.
  output logic      [31:0] out_tdata,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_MUL1,
    S_MUL2,
    S_MOD,
    S_DONE
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes complete on the access phase; pready is
  // tied high, so no transaction is extended by wait states.
  // --------------------------------------------------------------------------
  logic [31:0] initial_r;
  logic [31:0] max_r;
  logic [31:0] stable_r;
  logic        market_r;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_r <= '0;
      max_r     <= '0;
      stable_r  <= '0;
      market_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ebj_pkg::REG_INITIAL: initial_r <= cfg_pwdata;
        ebj_pkg::REG_MAXIMUM: max_r     <= cfg_pwdata;
        ebj_pkg::REG_STABLE:  stable_r  <= cfg_pwdata;
        ebj_pkg::REG_CHANNEL: market_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ebj_pkg::REG_INITIAL: cfg_prdata = initial_r;
      ebj_pkg::REG_MAXIMUM: cfg_prdata = max_r;
      ebj_pkg::REG_STABLE:  cfg_prdata = stable_r;
      ebj_pkg::REG_CHANNEL: cfg_prdata = {31'd0, market_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath state.
  // --------------------------------------------------------------------------
  state_t                     state_r, state_nxt;
  logic [63:0]                count_r, count_nxt;
  logic [31:0]                base_r, base_nxt;
  logic [ebj_pkg::SPAN_W-1:0] span_r, span_nxt;
  logic [31:0]                d_r, d_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [31:0]                out_tdata_r, out_tdata_nxt;

  // Serial unit hookup.
  logic                        mul_start;
  logic [63:0]                 mul_a;
  logic [63:0]                 mul_b;
  logic [63:0]                 mul_p;
  ebj_pkg::serial_stat_t       mul_stat;
  logic                        div_start;
  logic [63:0]                 div_dvd;
  logic [ebj_pkg::DSR_W-1:0]   div_dsr;
  logic [63:0]                 div_q;
  logic [ebj_pkg::DSR_W-1:0]   div_rem;
  ebj_pkg::serial_stat_t       div_stat;

  // Combinational helpers.
  logic                        in_acc;
  logic                        in_op;
  logic                        in_clear;
  logic                        in_ready_flag;
  logic [31:0]                 in_life;
  logic                        first_mul_done;
  logic [ebj_pkg::EXP_W-1:0]   exp_sel;
  logic [63:0]                 shifted;
  logic [31:0]                 base_calc;
  logic [63:0]                 hash_in;
  logic [63:0]                 mix_a;
  logic [63:0]                 mix_b;
  logic [63:0]                 seed;
  logic [33:0]                 jitter_sum;

  assign in_tready      = (state_r == S_IDLE);
  assign in_acc         = in_tvalid && in_tready;
  assign in_op          = in_tuser;
  assign in_clear       = in_acc && (in_op == ebj_pkg::OP_CLEAR);
  assign in_ready_flag  = in_tdata[0];
  assign in_life        = in_tdata[32:1];
  assign first_mul_done = (state_r == S_MUL1) && mul_stat.done;

  always_comb begin
    // Base delay: the initial delay doubled once per failure up to the cap.
    // A 32-bit value shifted by at most the cap never leaves 64 bits.
    if (count_r < 64'(ebj_pkg::EXP_CAP)) begin
      exp_sel = count_r[ebj_pkg::EXP_W-1:0];
    end else begin
      exp_sel = ebj_pkg::EXP_W'(ebj_pkg::EXP_CAP);
    end
    shifted = {32'd0, initial_r} << exp_sel;
    if (shifted > {32'd0, max_r}) begin
      base_calc = max_r;
    end else begin
      base_calc = shifted[31:0];
    end

    // Splitmix64 finalizer, split around the two serial multiplies.
    hash_in = (count_r + 64'd1) ^ (market_r ? ebj_pkg::CHAN_MARKET : ebj_pkg::CHAN_ACCOUNT);
    mix_a   = hash_in ^ (hash_in >> ebj_pkg::SHIFT_A);
    mix_b   = mul_p ^ (mul_p >> ebj_pkg::SHIFT_B);
    seed    = mul_p ^ (mul_p >> ebj_pkg::SHIFT_C);

    // base - span + (seed mod (2*span+1)); at most base + span, so 34 bits.
    jitter_sum = {2'b00, base_r} - {4'd0, span_r} + {1'b0, div_rem};
  end

  // Unit control. The first multiply and base / 5 start together and run the
  // same number of steps, so both finish in the same cycle.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = mix_a;
    mul_b     = ebj_pkg::SEED_MUL_A;
    div_start = 1'b0;
    div_dvd   = {32'd0, base_calc};
    div_dsr   = ebj_pkg::SPAN_DIVISOR;
    unique case (state_r)
      S_BASE: begin
        mul_start = 1'b1;
        div_start = 1'b1;
      end
      S_MUL1: begin
        mul_start = mul_stat.done;
        mul_a     = mix_b;
        mul_b     = ebj_pkg::SEED_MUL_B;
      end
      S_MUL2: begin
        div_start = mul_stat.done && (span_r != '0);
        div_dvd   = seed;
        div_dsr   = {2'b00, span_r, 1'b1};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    base_nxt       = base_r;
    span_nxt       = span_r;
    d_nxt          = d_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == ebj_pkg::OP_CLEAR) begin
            // Clear command: no result transaction.
            count_nxt = '0;
          end else begin
            // A stable session that reached ready forgives earlier failures.
            if (in_ready_flag && (in_life >= stable_r)) begin
              count_nxt = '0;
            end
            state_nxt = S_BASE;
          end
        end
      end
      S_BASE: begin
        base_nxt  = base_calc;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        if (mul_stat.done) begin
          span_nxt  = div_q[ebj_pkg::SPAN_W-1:0];
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_stat.done) begin
          if (span_r == '0) begin
            d_nxt     = base_r;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          if (jitter_sum > {2'b00, max_r}) begin
            d_nxt = max_r;
          end else begin
            d_nxt = jitter_sum[31:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the finished delay until the output register is free.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = d_r;
          count_nxt      = count_r + 64'd1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    base_r      <= base_nxt;
    span_r      <= span_nxt;
    d_r         <= d_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------------
  // Serial units.
  // --------------------------------------------------------------------------
  ebj_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .product (mul_p),
    .stat    (mul_stat)
  );

  ebj_serial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .quotient  (div_q),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `EBJ_ASSERT_SAME(a_delay_cap, out_tvalid_r, out_tdata_r <= max_r, "delay above maximum")
  `EBJ_ASSERT_NEXT(a_clear_zero, in_clear, count_r == 64'd0, "clear did not zero count")
  `EBJ_ASSERT_SAME(a_units_aligned, first_mul_done, div_stat.done, "divide lags multiply")
  `EBJ_ASSERT_SAME(a_idle_quiet, in_tready, !mul_stat.busy && !div_stat.busy, "unit busy in idle")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Backoff delay testbench
// Drives retry requests and clear commands into the backoff block. A local
// predictor mirrors the failure counter and the registers, and every delay
// that the block returns is checked against it. The run opens with a short
// table of directed rows and then goes through randomized phases with
// different register settings and handshake pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam bit [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Seed hash constants, kept locally so the prediction stands on its own.
  localparam bit [63:0] MIX_MUL_1         = 64'hbf58_476d_1ce4_e5b9;
  localparam bit [63:0] MIX_MUL_2         = 64'h94d0_49bb_1331_11eb;
  localparam bit [63:0] CHAN_MARKET_SEED  = 64'h0000_4d41_524b_4554;
  localparam bit [63:0] CHAN_ACCOUNT_SEED = 64'h0041_4343_4f55_4e54;

  // This pause covers a clear command or a request still in flight before
  // any register write.
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned PHASE_ITEMS    = 200;
  // Slowest clean run is roughly 820 requests plus the register pauses and
  // the long receiver hold; this limit allows several times that.
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;

  typedef enum bit {ROW_SEND, ROW_WRITE} row_kind_t;

  // One directed row: either a register write or a transaction on the input
  // channel. data is the register value or the lifetime. Where check is set,
  // want is the delay typed in by hand and replaces the predicted one.
  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] reg_idx;
    bit         op;
    bit         ready;
    bit [31:0]  data;
    bit         check;
    bit [31:0]  want;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 34;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    // All registers at reset: every delay is zero, stable threshold is zero.
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b1, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b1, ALL_ONES, 1'b1, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_CLEAR, 1'b1, ALL_ONES, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h1234_5678, 1'b1, 32'd0},
    // Initial equal to the cap and below five: span is zero, delay is the cap.
    '{ROW_WRITE, ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'd4, 1'b0, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_MAXIMUM, ebj_pkg::OP_NEXT,  1'b0, 32'd4, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b1, 32'd4},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b1, 32'd4},
    // Lifetime one short of the threshold, then exactly on it.
    '{ROW_WRITE, ebj_pkg::REG_STABLE,  ebj_pkg::OP_NEXT,  1'b0, ALL_ONES, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b1, 32'hFFFF_FFFE, 1'b1, 32'd4},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b1, ALL_ONES, 1'b1, 32'd4},
    '{ROW_WRITE, ebj_pkg::REG_CHANNEL, ebj_pkg::OP_NEXT,  1'b0, 32'd1, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b1, 32'd4},
    // Largest base: jitter above the cap gets clamped.
    '{ROW_WRITE, ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, ALL_ONES, 1'b0, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_MAXIMUM, ebj_pkg::OP_NEXT,  1'b0, ALL_ONES, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, ALL_ONES, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b1, ALL_ONES, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_CLEAR, 1'b0, 32'h0, 1'b0, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_CHANNEL, ebj_pkg::OP_NEXT,  1'b0, 32'd0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b0, 32'd0},
    // Doubling below the cap, then a cap that cuts into the jitter window.
    '{ROW_WRITE, ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'd1000, 1'b0, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_STABLE,  ebj_pkg::OP_NEXT,  1'b0, 32'd0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b1, 32'h0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b0, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_MAXIMUM, ebj_pkg::OP_NEXT,  1'b0, 32'd2500, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'd12345, 1'b0, 32'd0},
    // A zero cap forces a zero delay, and so does a zero initial delay.
    '{ROW_WRITE, ebj_pkg::REG_MAXIMUM, ebj_pkg::OP_NEXT,  1'b0, 32'd0, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b1, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'd0, 1'b0, 32'd0},
    '{ROW_WRITE, ebj_pkg::REG_MAXIMUM, ebj_pkg::OP_NEXT,  1'b0, ALL_ONES, 1'b0, 32'd0},
    '{ROW_SEND,  ebj_pkg::REG_INITIAL, ebj_pkg::OP_NEXT,  1'b0, 32'h0, 1'b1, 32'd0}
  };

  // Clock, reset and every block input start at known values.
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [39:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;

  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Local copy of the registers and the failure counter.
  bit [31:0] init_ms;
  bit [31:0] max_ms;
  bit [31:0] stable_ms;
  bit        market;
  bit [63:0] fail_count;

  // Delays still owed by the block, oldest first.
  bit [31:0] pending_delays [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Handshake pressure, set per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go        = 1'b0;
  int unsigned hold_left      = 0;

  exponential_backoff_jitter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input bit [31:0] got,
                                 input bit [31:0] want);
    $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Advances the local counter for one accepted transaction. Returns 1 with
  // the delay when the transaction owes a result, 0 for a clear command.
  function automatic bit next_delay(input bit op, input bit ready,
                                    input bit [31:0] life, output bit [31:0] delay);
    bit [63:0] expo;
    bit [63:0] base;
    bit [63:0] mix;
    bit [63:0] span;
    bit [63:0] total;
    delay = '0;
    if (op == ebj_pkg::OP_CLEAR) begin
      fail_count = '0;
      return 1'b0;
    end
    // A session that reached ready and lasted long enough forgives the past.
    if (ready && life >= stable_ms) fail_count = '0;
    expo = (fail_count < ebj_pkg::EXP_CAP) ? fail_count : 64'(ebj_pkg::EXP_CAP);
    // A 32-bit value shifted by at most the cap always fits in 64 bits.
    base = {32'b0, init_ms} << expo;
    if (base > {32'b0, max_ms}) base = {32'b0, max_ms};
    // Splitmix64 finalizer over the next count, salted by the channel.
    mix = (fail_count + 64'd1) ^ (market ? CHAN_MARKET_SEED : CHAN_ACCOUNT_SEED);
    mix = mix ^ (mix >> 30);
    mix = mix * MIX_MUL_1;
    mix = mix ^ (mix >> 27);
    mix = mix * MIX_MUL_2;
    mix = mix ^ (mix >> 31);
    // Jitter is uniform over [-span, +span]; the low end never drops below 0.
    span = base / 64'd5;
    total = (span == 64'd0) ? base : base - span + mix % (64'd2 * span + 64'd1);
    if (total > {32'b0, max_ms}) total = {32'b0, max_ms};
    fail_count = fail_count + 64'd1;
    delay = total[31:0];
    return 1'b1;
  endfunction

  // Drops the input valid and waits until the block has nothing left to give,
  // plus enough cycles for a clear command or a stray request to finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_delays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register, then reads it back in a second transfer. The local
  // copy is updated first since the block is idle at this point.
  task automatic cfg_write(input logic [1:0] idx, input bit [31:0] value);
    bit [31:0] stored;
    stored = (idx == ebj_pkg::REG_CHANNEL) ? {31'b0, value[0]} : value;
    case (idx)
      ebj_pkg::REG_INITIAL: init_ms   = value;
      ebj_pkg::REG_MAXIMUM: max_ms    = value;
      ebj_pkg::REG_STABLE:  stable_ms = value;
      ebj_pkg::REG_CHANNEL: market    = value[0];
      default: ;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // Straight into the setup phase of the read-back.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== stored) report_mismatch("register read-back", cfg_prdata, stored);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Offers one transaction, possibly after a few idle cycles, and holds it
  // until the block takes it. Valid stays high on exit so that back-to-back
  // transactions need no extra cycle.
  task automatic send_item(input bit op, input bit ready, input bit [31:0] life,
                           input bit check, input bit [31:0] want);
    bit [31:0] predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, life, ready};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (next_delay(op, ready, life, predicted)) begin
      pending_delays.push_back(check ? want : predicted);
    end
  endtask

  // Result side ready. A long hold, once requested, keeps ready low so the
  // block backs up and stalls its input; otherwise ready drops at random.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every accepted result is matched against the oldest owed delay.
  always @(posedge clk) begin
    bit [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_delays.size() == 0) begin
        report_mismatch("unexpected delay", out_tdata, 32'd0);
      end else begin
        want = pending_delays.pop_front();
        if (out_tdata !== want) report_mismatch("delay_ms", out_tdata, want);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    bit        op;
    bit        ready;
    bit [31:0] life;
    stim_row_t row;

    init_ms    = '0;
    max_ms     = '0;
    stable_ms  = '0;
    market     = 1'b0;
    fail_count = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: register writes wait for the block to go idle.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        cfg_write(row.reg_idx, row.data);
      end else begin
        send_item(row.op, row.ready, row.data, row.check, row.want);
      end
    end

    // Random phases. Phase 0 runs flat out with one long receiver hold;
    // then sender gaps, receiver stalls, and both together.
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // Even phases use a small initial delay so the doubling stays visible
      // below a wide cap; the first two keep the stable threshold at its top
      // so the counter runs up past the exponent cap.
      cfg_write(ebj_pkg::REG_INITIAL,
                (phase % 2 == 0) ? 32'($urandom_range(1, 3000)) : $urandom);
      cfg_write(ebj_pkg::REG_MAXIMUM, (phase == 0) ? ALL_ONES : $urandom);
      cfg_write(ebj_pkg::REG_STABLE, (phase < 2) ? ALL_ONES : $urandom);
      cfg_write(ebj_pkg::REG_CHANNEL, 32'(phase % 2));
      if (phase == 0) hold_go = 1'b1;

      repeat (PHASE_ITEMS) begin
        op    = ($urandom_range(0, 99) < 4) ? ebj_pkg::OP_CLEAR : ebj_pkg::OP_NEXT;
        ready = $urandom_range(0, 1);
        // Lifetimes cluster at the threshold edges and the field extremes.
        case ($urandom_range(0, 9))
          0: life = ALL_ONES;
          1: life = stable_ms;
          2: life = stable_ms - 32'd1;
          3: life = 32'd0;
          default: life = $urandom;
        endcase
        send_item(op, ready, life, 1'b0, 32'd0);
      end
    end

    // Drain, give a late extra result time to show up, then report.
    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
